[hw/rtl/cds_pkg.sv]
// Shared types, constants and date helper functions for the calendar date stepper.
`default_nettype none

package cds_pkg;

  localparam int REQ_W  = 2;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int DIFF_W = 23;

  // day number relative to an internal epoch, max about 3.65e6
  localparam int DN_W   = 22;
  // year modulo 400
  localparam int R400_W = 9;
  // day plus month offset, max 368
  localparam int DM_W   = 9;
  // floor(yy / 4), max 2499
  localparam int Q4_W   = 12;
  // floor(yy / 100), max 99
  localparam int D100_W = 7;
  // floor(yy / 400), max 24
  localparam int D400_W = 5;
  // floor(year / 400) for any 14-bit year, max 40
  localparam int Q400_W = 6;

  // x / 25 == (x * 5243) >> 17, exact for x below 16384
  localparam int RECIP_25    = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 17;

  localparam int DAYS_PER_YEAR = 365;
  localparam int CYCLE_YEARS   = 400;
  localparam int YEAR_MAX      = 9999;

  // day number of 0001-01-01 in the internal epoch
  localparam logic [DN_W-1:0] DN_RESET = 22'd307;

  localparam logic [DAY_W-1:0]  DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]  DAY_LAST  = 5'd31;
  localparam logic [MON_W-1:0]  MON_JAN   = 4'd1;
  localparam logic [MON_W-1:0]  MON_FEB   = 4'd2;
  localparam logic [MON_W-1:0]  MON_DEC   = 4'd12;
  localparam logic [YEAR_W-1:0] YEAR_FIRST = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_LAST  = 14'd9999;
  localparam logic [R400_W-1:0] R400_LAST  = 9'd399;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_FWD  = 2'd1,
    REQ_BACK = 2'd2,
    REQ_DIFF = 2'd3
  } req_t;

  typedef struct packed {
    req_t              req;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  mon;
    logic [YEAR_W-1:0] year;
  } arg_t;

  typedef struct packed {
    arg_t              arg;
    logic [Q400_W-1:0] q400;
    logic [DN_W-1:0]   yy365;
    logic [Q4_W-1:0]   q4;
    logic [D100_W-1:0] d100;
    logic [D400_W-1:0] d400;
    logic [DM_W-1:0]   dm;
  } s2_t;

  typedef struct packed {
    arg_t              arg;
    logic [R400_W-1:0] r400;
    logic              ok;
    logic [DN_W-1:0]   dn;
  } s3_t;

  // Gregorian leap rule on the year modulo 400
  function automatic logic is_leap(input logic [R400_W-1:0] r400);
    logic century;
    century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (r400[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // (153 * mm + 2) / 5 with March as month zero
  function automatic logic [DM_W-1:0] month_offset(input logic [MON_W-1:0] m);
    logic [DM_W-1:0] ofs;
    unique case (m)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/calendar_date_stepper_top.sv]
// Calendar date stepper: kept Gregorian date with load, step and day-difference items.
//
// Usage
//   Input channel  in_valid / in_stall carries one item: in_req_type plus an
//   argument date (in_arg_day, in_arg_month, in_arg_year). Load and difference
//   use the argument; forward and back steps ignore it.
//   Result channel out_valid / out_stall returns one item per input item: the
//   kept date after the item, the signed day difference (kept minus argument,
//   zero unless a valid difference item) and the range_error flag.
//   Pipeline: input register, two stages that turn the argument into a day
//   number, result register. Throughput: one item per cycle unless
//   out_stall holds a result. The limit is the kept-date loop in the last
//   stage, which updates date, day number and year-mod-400 together.
//   Reset: kept date 0001-01-01, all stages empty.
//   Stall: a result held by out_stall blocks only the last stage; earlier
//   stages keep filling, so up to four items sit inside before in_stall rises.
//   The kept date is tracked as a running day number, so a difference is one
//   subtraction; no leap logic on the full year is needed, only year mod 400.
`default_nettype none

module calendar_date_stepper_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cds_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [cds_pkg::DAY_W-1:0]   in_arg_day,
  input  wire logic [cds_pkg::MON_W-1:0]   in_arg_month,
  input  wire logic [cds_pkg::YEAR_W-1:0]  in_arg_year,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [cds_pkg::DAY_W-1:0]        out_day,
  output logic [cds_pkg::MON_W-1:0]        out_month,
  output logic [cds_pkg::YEAR_W-1:0]       out_year,
  output logic signed [cds_pkg::DIFF_W-1:0] out_day_difference,
  output logic                             out_range_error
);
  import cds_pkg::*;

  localparam int P100_W = Q4_W + RECIP_W;
  localparam int P400_W = (YEAR_W - 4) + RECIP_W;

  // stage valids
  logic v1_r, v2_r, v3_r, vo_r;
  logic fire_in, fire1, fire2, fire3;
  logic free1, free2, free3, free_o;

  arg_t s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;

  // kept date state
  logic [DAY_W-1:0]  cur_day_r,  cur_day_nxt;
  logic [MON_W-1:0]  cur_mon_r,  cur_mon_nxt;
  logic [YEAR_W-1:0] cur_year_r, cur_year_nxt;
  logic [DN_W-1:0]   cur_dn_r,   cur_dn_nxt;
  logic [R400_W-1:0] cur_r400_r, cur_r400_nxt;
  logic [DIFF_W-1:0] diff_r, diff_nxt;
  logic              err_r,  err_nxt;

  // ---------------- handshake: bubbles collapse, stall only where full
  assign free_o   = !vo_r || !out_stall;
  assign fire3    = v3_r && free_o;
  assign free3    = !v3_r || fire3;
  assign fire2    = v2_r && free3;
  assign free2    = !v2_r || fire2;
  assign fire1    = v1_r && free2;
  assign free1    = !v1_r || fire1;
  assign in_stall = !free1;
  assign fire_in  = in_valid && free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= fire_in || (v1_r && !fire1);
      v2_r <= fire1   || (v2_r && !fire2);
      v3_r <= fire2   || (v3_r && !fire3);
      vo_r <= fire3   || (vo_r && out_stall);
    end
  end

  // ---------------- input register
  always_comb begin
    s1_nxt.req  = req_t'(in_req_type);
    s1_nxt.day  = in_arg_day;
    s1_nxt.mon  = in_arg_month;
    s1_nxt.year = in_arg_year;
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------- stage 2: products of the argument day number
  // yy is the March-based year; quotients by 100 and 400 go through /25.
  logic [YEAR_W-1:0] yy;
  logic [P100_W-1:0] prod100;
  logic [P400_W-1:0] prod400, prod_q400;

  always_comb begin
    yy        = s1_r.year - YEAR_W'(s1_r.mon <= MON_FEB);
    prod100   = P100_W'(yy[YEAR_W-1:2]) * P100_W'(RECIP_25);
    prod400   = P400_W'(yy[YEAR_W-1:4]) * P400_W'(RECIP_25);
    prod_q400 = P400_W'(s1_r.year[YEAR_W-1:4]) * P400_W'(RECIP_25);

    s2_nxt.arg   = s1_r;
    s2_nxt.q400  = prod_q400[RECIP_SHIFT +: Q400_W];
    s2_nxt.yy365 = DN_W'(yy) * DN_W'(DAYS_PER_YEAR);
    s2_nxt.q4    = yy[YEAR_W-1:2];
    s2_nxt.d100  = prod100[RECIP_SHIFT +: D100_W];
    s2_nxt.d400  = prod400[RECIP_SHIFT +: D400_W];
    s2_nxt.dm    = DM_W'(s1_r.day) + month_offset(s1_r.mon);
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------- stage 3: argument day number and validity
  logic [YEAR_W-1:0] r400_wide;
  logic              arg_leap;

  always_comb begin
    r400_wide = s2_r.arg.year - YEAR_W'(YEAR_W'(s2_r.q400) * YEAR_W'(CYCLE_YEARS));
    arg_leap  = is_leap(r400_wide[R400_W-1:0]);

    s3_nxt.arg  = s2_r.arg;
    s3_nxt.r400 = r400_wide[R400_W-1:0];
    s3_nxt.ok   = (s2_r.arg.year >= YEAR_FIRST) && (s2_r.arg.year <= YEAR_LAST) &&
                  (s2_r.arg.mon >= MON_JAN) && (s2_r.arg.mon <= MON_DEC) &&
                  (s2_r.arg.day >= DAY_FIRST) &&
                  (s2_r.arg.day <= month_len(s2_r.arg.mon, arg_leap));
    s3_nxt.dn   = DN_W'(s2_r.dm) + s2_r.yy365 + DN_W'(s2_r.q4)
                  - DN_W'(s2_r.d100) + DN_W'(s2_r.d400);
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      s3_r <= s3_nxt;
    end
  end

  // ---------------- last stage: kept date update and result
  logic             cur_leap;
  logic [MON_W-1:0] prev_mon;
  logic             at_end, at_start;

  always_comb begin
    cur_leap = is_leap(cur_r400_r);
    prev_mon = (cur_mon_r == MON_JAN) ? MON_DEC : cur_mon_r - 1'b1;
    at_end   = (cur_day_r == DAY_LAST) && (cur_mon_r == MON_DEC) &&
               (cur_year_r == YEAR_LAST);
    at_start = (cur_day_r == DAY_FIRST) && (cur_mon_r == MON_JAN) &&
               (cur_year_r == YEAR_FIRST);

    cur_day_nxt  = cur_day_r;
    cur_mon_nxt  = cur_mon_r;
    cur_year_nxt = cur_year_r;
    cur_dn_nxt   = cur_dn_r;
    cur_r400_nxt = cur_r400_r;
    diff_nxt     = '0;
    err_nxt      = 1'b0;

    unique case (s3_r.arg.req)
      REQ_LOAD: begin
        if (s3_r.ok) begin
          cur_day_nxt  = s3_r.arg.day;
          cur_mon_nxt  = s3_r.arg.mon;
          cur_year_nxt = s3_r.arg.year;
          cur_dn_nxt   = s3_r.dn;
          cur_r400_nxt = s3_r.r400;
        end else begin
          err_nxt = 1'b1;
        end
      end
      REQ_FWD: begin
        if (at_end) begin
          err_nxt = 1'b1;
        end else begin
          cur_dn_nxt = cur_dn_r + 1'b1;
          if (cur_day_r < month_len(cur_mon_r, cur_leap)) begin
            cur_day_nxt = cur_day_r + 1'b1;
          end else begin
            cur_day_nxt = DAY_FIRST;
            if (cur_mon_r == MON_DEC) begin
              cur_mon_nxt  = MON_JAN;
              cur_year_nxt = cur_year_r + 1'b1;
              cur_r400_nxt = (cur_r400_r == R400_LAST) ? '0 : cur_r400_r + 1'b1;
            end else begin
              cur_mon_nxt = cur_mon_r + 1'b1;
            end
          end
        end
      end
      REQ_BACK: begin
        if (at_start) begin
          err_nxt = 1'b1;
        end else begin
          cur_dn_nxt = cur_dn_r - 1'b1;
          if (cur_day_r > DAY_FIRST) begin
            cur_day_nxt = cur_day_r - 1'b1;
          end else begin
            // December has 31 days whatever the year, so the current leap flag serves
            cur_mon_nxt = prev_mon;
            cur_day_nxt = month_len(prev_mon, cur_leap);
            if (cur_mon_r == MON_JAN) begin
              cur_year_nxt = cur_year_r - 1'b1;
              cur_r400_nxt = (cur_r400_r == '0) ? R400_LAST : cur_r400_r - 1'b1;
            end
          end
        end
      end
      REQ_DIFF: begin
        if (s3_r.ok) begin
          diff_nxt = DIFF_W'(cur_dn_r) - DIFF_W'(s3_r.dn);
        end else begin
          err_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_day_r  <= DAY_FIRST;
      cur_mon_r  <= MON_JAN;
      cur_year_r <= YEAR_FIRST;
      cur_dn_r   <= DN_RESET;
      cur_r400_r <= R400_W'(1);
    end else if (fire3) begin
      cur_day_r  <= cur_day_nxt;
      cur_mon_r  <= cur_mon_nxt;
      cur_year_r <= cur_year_nxt;
      cur_dn_r   <= cur_dn_nxt;
      cur_r400_r <= cur_r400_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire3) begin
      diff_r <= diff_nxt;
      err_r  <= err_nxt;
    end
  end

  // kept date only changes together with the result register
  assign out_valid          = vo_r;
  assign out_day            = cur_day_r;
  assign out_month          = cur_mon_r;
  assign out_year           = cur_year_r;
  assign out_day_difference = signed'(diff_r);
  assign out_range_error    = err_r;

  // ---------------- assertions
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_mon_r >= MON_JAN) && (cur_mon_r <= MON_DEC) && (cur_day_r >= DAY_FIRST) &&
    (cur_day_r <= month_len(cur_mon_r, cur_leap)))
    else $error("kept date is not a legal date");

  a_r400_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r400_r <= R400_LAST)
    else $error("year modulo 400 out of range");

  a_fwd_dn: assert property (@(posedge clk) disable iff (!rst_n)
    fire3 && (s3_r.arg.req == REQ_FWD) && !err_nxt |=>
      cur_dn_r == $past(cur_dn_r) + 1'b1)
    else $error("forward step did not advance the day number by one");

  a_diff_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    fire3 && (s3_r.arg.req == REQ_DIFF) |=>
      $stable(cur_day_r) && $stable(cur_mon_r) && $stable(cur_year_r) && $stable(cur_dn_r))
    else $error("difference item changed the kept date");

endmodule

`default_nettype wire
